### rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// types, codes and sizes shared by the generational handle allocator
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int GEN_BITS   = 32;
  localparam int IDX_BITS   = $clog2(SLOT_COUNT);
  localparam int CNT_BITS   = $clog2(SLOT_COUNT + 1);

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_CREATE  = 2'd0;
  localparam mode_t MODE_DESTROY = 2'd1;
  localparam mode_t MODE_CHECK   = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_STALE = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef struct packed {
    mode_t                 mode;
    logic [IDX_BITS-1:0]   handle_index;
    logic [GEN_BITS-1:0]   handle_generation;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic                  is_alive;
    logic [IDX_BITS-1:0]   new_index;
    logic [GEN_BITS-1:0]   new_generation;
    logic [CNT_BITS-1:0]   live_total;
  } resp_t;

  // slot table entry: alive flag next to the generation
  typedef struct packed {
    logic                  alive;
    logic [GEN_BITS-1:0]   gen;
  } slot_entry_t;

  // free stack entry keeps the generation the slot will be reissued with
  typedef struct packed {
    logic [IDX_BITS-1:0]   idx;
    logic [GEN_BITS-1:0]   gen;
  } stack_entry_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   addr;
  } mem_rd_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   addr;
    slot_entry_t           entry;
  } slot_wr_t;

  typedef struct packed {
    logic                  en;
    logic [IDX_BITS-1:0]   addr;
    stack_entry_t          entry;
  } stack_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

### rtl/gha_slot_table.sv
// ----------------------------------------------------------------------------
// gha_slot_table
// per-slot alive flag and generation, one read and one write port
// ----------------------------------------------------------------------------
module gha_slot_table (
  input  logic                 clk,
  input  gha_pkg::mem_rd_t     rd,
  output gha_pkg::slot_entry_t rd_data,
  input  gha_pkg::slot_wr_t    wr
);

  gha_pkg::slot_entry_t mem [gha_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/gha_free_stack.sv
// ----------------------------------------------------------------------------
// gha_free_stack
// storage for freed slots, one read and one write port
// ----------------------------------------------------------------------------
module gha_free_stack (
  input  logic                  clk,
  input  gha_pkg::mem_rd_t      rd,
  output gha_pkg::stack_entry_t rd_data,
  input  gha_pkg::stack_wr_t    wr
);

  gha_pkg::stack_entry_t mem [gha_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator
// each request reads the slot table and the free stack top at the accept edge;
// in EXEC, once the response register is free, it writes back and loads the
// response register; no new request is taken until that read-modify-write ends
// a new request is taken while the previous response still waits
// reset (rst, synchronous) empties the allocator at once; no clearing pass
// ----------------------------------------------------------------------------
module generational_handle_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  gha_pkg::req_t  req,
  output logic           resp_valid,
  input  logic           resp_ready,
  output gha_pkg::resp_t resp
);

  localparam int CNT_BITS = gha_pkg::CNT_BITS;
  localparam int IDX_BITS = gha_pkg::IDX_BITS;
  localparam int GEN_BITS = gha_pkg::GEN_BITS;
  localparam logic [CNT_BITS-1:0] SLOTS = CNT_BITS'(gha_pkg::SLOT_COUNT);

  gha_pkg::state_t       state;
  gha_pkg::req_t         req_q;

  // free stack depth, fill mark of never-used slots, live handle count
  logic [CNT_BITS-1:0]   free_top;
  logic [CNT_BITS-1:0]   free_top_next;
  logic [CNT_BITS-1:0]   high_water;
  logic [CNT_BITS-1:0]   high_water_next;
  logic [CNT_BITS-1:0]   live_count;
  logic [CNT_BITS-1:0]   live_count_next;
  logic [CNT_BITS-1:0]   top_dec;

  gha_pkg::mem_rd_t      slot_rd;
  gha_pkg::mem_rd_t      stack_rd;
  gha_pkg::slot_entry_t  slot_data;
  gha_pkg::stack_entry_t stack_data;
  gha_pkg::slot_wr_t     slot_wr;
  gha_pkg::stack_wr_t    stack_wr;
  gha_pkg::resp_t        resp_next;

  logic                  accept;
  logic                  finish;
  logic                  handle_live;
  logic [GEN_BITS-1:0]   gen_inc;

  // only IDLE takes a request; EXEC finishes once the response register is free
  assign req_ready = (state == gha_pkg::ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign finish    = (state == gha_pkg::ST_EXEC) && (!resp_valid || resp_ready);

  // read addresses are set at the accept edge: the slot index straight from the request, the free stack at its top
  assign top_dec        = free_top - 1'b1;
  assign slot_rd.en     = accept;
  assign slot_rd.addr   = req.handle_index;
  assign stack_rd.en    = accept;
  assign stack_rd.addr  = top_dec[IDX_BITS-1:0];

  gha_slot_table u_slot_table (
    .clk     (clk),
    .rd      (slot_rd),
    .rd_data (slot_data),
    .wr      (slot_wr)
  );

  gha_free_stack u_free_stack (
    .clk     (clk),
    .rd      (stack_rd),
    .rd_data (stack_data),
    .wr      (stack_wr)
  );

  // slots at or above the fill mark were never handed out, so their table
  // contents are never trusted; the index compare screens them off
  assign handle_live = (req_q.handle_generation != '0)
                    && ({1'b0, req_q.handle_index} < high_water)
                    && slot_data.alive
                    && (slot_data.gen == req_q.handle_generation);

  assign gen_inc = slot_data.gen + 1'b1;

  always_comb begin
    slot_wr         = '0;
    stack_wr        = '0;
    resp_next       = '0;
    free_top_next   = free_top;
    high_water_next = high_water;
    live_count_next = live_count;

    unique case (req_q.mode)
      gha_pkg::MODE_CREATE: begin
        if (free_top != '0) begin
          // reuse the most recently freed slot with its stored generation
          slot_wr.en               = finish;
          slot_wr.addr             = stack_data.idx;
          slot_wr.entry.alive      = 1'b1;
          slot_wr.entry.gen        = stack_data.gen;
          free_top_next            = top_dec;
          live_count_next          = live_count + 1'b1;
          resp_next.new_index      = stack_data.idx;
          resp_next.new_generation = stack_data.gen;
        end else if (high_water < SLOTS) begin
          // fresh slot starts at generation one
          slot_wr.en               = finish;
          slot_wr.addr             = high_water[IDX_BITS-1:0];
          slot_wr.entry.alive      = 1'b1;
          slot_wr.entry.gen        = GEN_BITS'(1);
          high_water_next          = high_water + 1'b1;
          live_count_next          = live_count + 1'b1;
          resp_next.new_index      = high_water[IDX_BITS-1:0];
          resp_next.new_generation = GEN_BITS'(1);
        end else begin
          resp_next.status         = gha_pkg::STATUS_FULL;
        end
      end
      gha_pkg::MODE_DESTROY: begin
        resp_next.is_alive = handle_live;
        if (!handle_live) begin
          resp_next.status = gha_pkg::STATUS_STALE;
        end else begin
          slot_wr.en          = finish;
          slot_wr.addr        = req_q.handle_index;
          slot_wr.entry.alive = 1'b0;
          if (gen_inc == '0) begin
            // generation wrapped: park at one and retire the slot
            slot_wr.entry.gen = GEN_BITS'(1);
          end else begin
            slot_wr.entry.gen = gen_inc;
            if (free_top < SLOTS) begin
              stack_wr.en        = finish;
              stack_wr.addr      = free_top[IDX_BITS-1:0];
              stack_wr.entry.idx = req_q.handle_index;
              stack_wr.entry.gen = gen_inc;
              free_top_next      = free_top + 1'b1;
            end
          end
          if (live_count != '0) begin
            live_count_next = live_count - 1'b1;
          end
        end
      end
      gha_pkg::MODE_CHECK: begin
        resp_next.is_alive = handle_live;
        if (!handle_live) begin
          resp_next.status = gha_pkg::STATUS_STALE;
        end
      end
      default: begin
        // unused mode leaves all state alone
      end
    endcase

    resp_next.live_total = live_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gha_pkg::ST_IDLE;
      resp_valid <= 1'b0;
      free_top   <= '0;
      high_water <= '0;
      live_count <= '0;
    end else begin
      unique case (state)
        gha_pkg::ST_IDLE: begin
          if (accept) begin
            state <= gha_pkg::ST_EXEC;
          end
        end
        gha_pkg::ST_EXEC: begin
          if (finish) begin
            state      <= gha_pkg::ST_IDLE;
            free_top   <= free_top_next;
            high_water <= high_water_next;
            live_count <= live_count_next;
          end
        end
        default: begin
          state <= gha_pkg::ST_IDLE;
        end
      endcase

      if (finish) begin
        resp_valid <= 1'b1;
      end else if (resp_ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  // payload registers: request capture and response
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (finish) begin
      resp <= resp_next;
    end
  end

endmodule

### rtl/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// port-level checks for the generational handle allocator
// ----------------------------------------------------------------------------
module gha_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input gha_pkg::req_t  req,
  input logic           resp_valid,
  input logic           resp_ready,
  input gha_pkg::resp_t resp
);

  // a stalled response holds
  assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp))
    else $error("stalled response changed");

  // one request at a time: no accept right after an accept
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken back to back");

  // a handed-out handle is counted as live
  assert property (@(posedge clk) disable iff (rst)
    resp_valid && (resp.new_generation != '0)
      |-> (resp.status == gha_pkg::STATUS_OK) && (resp.live_total != '0))
    else $error("created handle without live count");

  // live count never exceeds the slot count
  assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> resp.live_total <= gha_pkg::CNT_BITS'(gha_pkg::SLOT_COUNT))
    else $error("live count out of range");

  // reset drops any pending response and reopens the request side
  assert property (@(posedge clk)
    rst |=> !resp_valid && req_ready)
    else $error("reset did not clear response");

endmodule

bind generational_handle_allocator gha_checker u_gha_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req_valid),
  .req_ready  (req_ready),
  .req        (req),
  .resp_valid (resp_valid),
  .resp_ready (resp_ready),
  .resp       (resp)
);
